[sv/gfm_pkg.sv]
// ----------------------------------------------------------------------------
// GF(2^283) multiplier package
// Field sizes, limb widths, the pentanomial taps and the pipeline payload type
// that the multiplier modules use.
// ----------------------------------------------------------------------------
package gfm_pkg;

	// Field and limb geometry.
	localparam int FIELD_BITS = 283;
	localparam int PROD_BITS  = 2 * FIELD_BITS - 1;
	localparam int LIMB_W     = 64;
	localparam int TOP_W      = 27;

	// Bits of the second operand that one accumulate stage consumes.
	localparam int CHUNK_W_DEF = 32;

	// Low taps of x^283 + x^12 + x^7 + x^5 + 1.
	localparam int TAP_A = 5;
	localparam int TAP_B = 7;
	localparam int TAP_C = 12;

	// Width after the first fold: the high half shifted by the top tap.
	localparam int FOLD_BITS = PROD_BITS - FIELD_BITS + TAP_C;
	localparam int OVF_BITS  = FOLD_BITS - FIELD_BITS;

	typedef logic [FIELD_BITS-1:0] elem_t;
	typedef logic [PROD_BITS-1:0]  prod_t;
	typedef logic [FOLD_BITS-1:0]  fold_t;

	// Payload that travels down the accumulate pipeline.
	typedef struct packed {
		elem_t a;
		elem_t b;
		prod_t acc;
	} mac_data_t;

endpackage

[sv/gfm_op_if.sv]
// ----------------------------------------------------------------------------
// Operand channel
// Valid/ready channel carrying both field operands as five limbs each.
// ----------------------------------------------------------------------------
interface gfm_op_if;
	import gfm_pkg::*;

	logic              valid;
	logic              ready;
	logic [LIMB_W-1:0] a_limb0;
	logic [LIMB_W-1:0] a_limb1;
	logic [LIMB_W-1:0] a_limb2;
	logic [LIMB_W-1:0] a_limb3;
	logic [TOP_W-1:0]  a_limb4;
	logic [LIMB_W-1:0] b_limb0;
	logic [LIMB_W-1:0] b_limb1;
	logic [LIMB_W-1:0] b_limb2;
	logic [LIMB_W-1:0] b_limb3;
	logic [TOP_W-1:0]  b_limb4;

	modport source (
		output valid, a_limb0, a_limb1, a_limb2, a_limb3, a_limb4,
		output b_limb0, b_limb1, b_limb2, b_limb3, b_limb4,
		input  ready
	);
	modport sink (
		input  valid, a_limb0, a_limb1, a_limb2, a_limb3, a_limb4,
		input  b_limb0, b_limb1, b_limb2, b_limb3, b_limb4,
		output ready
	);
endinterface

[sv/gfm_res_if.sv]
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the reduced product as five limbs.
// ----------------------------------------------------------------------------
interface gfm_res_if;
	import gfm_pkg::*;

	logic              valid;
	logic              ready;
	logic [LIMB_W-1:0] product_limb0;
	logic [LIMB_W-1:0] product_limb1;
	logic [LIMB_W-1:0] product_limb2;
	logic [LIMB_W-1:0] product_limb3;
	logic [TOP_W-1:0]  product_limb4;

	modport source (
		output valid, product_limb0, product_limb1, product_limb2,
		output product_limb3, product_limb4,
		input  ready
	);
	modport sink (
		input  valid, product_limb0, product_limb1, product_limb2,
		input  product_limb3, product_limb4,
		output ready
	);
endinterface

[sv/gf2_283_field_multiplier_unit.sv]
// Stages: ceil(283 / CHUNK_W) accumulate stages plus two reduction stages.
// Throughput: one transaction per cycle; every stage has its own valid bit
// and advances when its successor is empty or draining; res.ready may stall it.
// Reset clears all valid bits asynchronously; the data registers are not reset.
// ----------------------------------------------------------------------------
// GF(2^283) field multiplier
// Pipelined carry-less multiplier with pentanomial reduction: operand b is
// consumed one chunk per stage, then the 565-bit product is folded to 283 bits.
// ----------------------------------------------------------------------------
module gf2_283_field_multiplier_unit #(
	parameter int CHUNK_W = gfm_pkg::CHUNK_W_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	gfm_op_if.sink  op,
	gfm_res_if.source res
);
	import gfm_pkg::*;

	localparam int MAC_STAGES = (FIELD_BITS + CHUNK_W - 1) / CHUNK_W;

	logic      stg_valid [MAC_STAGES+1];
	logic      stg_ready [MAC_STAGES+1];
	mac_data_t stg_data  [MAC_STAGES+1];
	elem_t     result;

	// Pack the incoming limbs into field elements with an empty accumulator.
	assign stg_data[0].a   = {op.a_limb4, op.a_limb3, op.a_limb2, op.a_limb1, op.a_limb0};
	assign stg_data[0].b   = {op.b_limb4, op.b_limb3, op.b_limb2, op.b_limb1, op.b_limb0};
	assign stg_data[0].acc = '0;

	assign stg_valid[0] = op.valid;
	assign op.ready     = stg_ready[0];

	// Accumulate pipeline: stage i handles bits [i*CHUNK_W +: CHUNK_W] of b.
	for (genvar i = 0; i < MAC_STAGES; i++) begin : g_mac
		gfm_mac_stage #(
			.OFFSET  (i * CHUNK_W),
			.CHUNK_W (CHUNK_W)
		) u_mac (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (stg_valid[i]),
			.in_ready  (stg_ready[i]),
			.in_data   (stg_data[i]),
			.out_valid (stg_valid[i+1]),
			.out_ready (stg_ready[i+1]),
			.out_data  (stg_data[i+1])
		);
	end

	// Reduction; its last stage is the output register.
	gfm_reduce u_reduce (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (stg_valid[MAC_STAGES]),
		.in_ready  (stg_ready[MAC_STAGES]),
		.in_prod   (stg_data[MAC_STAGES].acc),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.out_elem  (result)
	);

	// Split the reduced element into limbs.
	assign res.product_limb0 = result[0*LIMB_W +: LIMB_W];
	assign res.product_limb1 = result[1*LIMB_W +: LIMB_W];
	assign res.product_limb2 = result[2*LIMB_W +: LIMB_W];
	assign res.product_limb3 = result[3*LIMB_W +: LIMB_W];
	assign res.product_limb4 = result[4*LIMB_W +: TOP_W];

endmodule

[sv/gfm_mac_stage.sv]
// ----------------------------------------------------------------------------
// Carry-less accumulate stage
// One pipeline stage that XORs the shifted copies of operand a selected by
// one chunk of operand b into the running product, then registers the result.
// ----------------------------------------------------------------------------
module gfm_mac_stage #(
	parameter int OFFSET  = 0,
	parameter int CHUNK_W = gfm_pkg::CHUNK_W_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  gfm_pkg::mac_data_t in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output gfm_pkg::mac_data_t out_data
);
	import gfm_pkg::*;

	logic      valid_s1;
	mac_data_t data_s1;
	mac_data_t next_data;

	// Partial products of this chunk; each term is independent, so this is a
	// flat XOR tree of depth at most ceil(log2(CHUNK_W + 1)) with the accumulator.
	always_comb begin
		next_data     = in_data;
		next_data.acc = in_data.acc;
		for (int k = 0; k < CHUNK_W; k++) begin
			if ((OFFSET + k) < FIELD_BITS) begin
				if (in_data.b[OFFSET + k]) begin
					next_data.acc = next_data.acc ^ (PROD_BITS'(in_data.a) << (OFFSET + k));
				end
			end
		end
	end

	// The stage takes a new transaction when it is empty or being drained.
	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= next_data;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

[sv/gfm_reduce.sv]
// ----------------------------------------------------------------------------
// Pentanomial reduction
// Two pipeline stages that fold the 565-bit product modulo
// x^283 + x^12 + x^7 + x^5 + 1: a wide fold of the high half, then a short
// fold of the few bits that the first one pushes past bit 282.
// ----------------------------------------------------------------------------
module gfm_reduce (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  gfm_pkg::prod_t in_prod,
	output logic           out_valid,
	input  logic           out_ready,
	output gfm_pkg::elem_t out_elem
);
	import gfm_pkg::*;

	localparam int HI_BITS = PROD_BITS - FIELD_BITS;

	logic                valid_s1;
	logic                valid_s2;
	fold_t               fold_s1;
	elem_t               res_s2;
	logic                ready_s1;
	logic [HI_BITS-1:0]  hi;
	fold_t               fold_next;
	logic [OVF_BITS-1:0] ovf;
	elem_t               res_next;

	// First fold: x^283 == x^12 + x^7 + x^5 + 1, applied to the high half.
	always_comb begin
		hi        = in_prod[PROD_BITS-1:FIELD_BITS];
		fold_next = FOLD_BITS'(in_prod[FIELD_BITS-1:0])
			^ FOLD_BITS'(hi)
			^ (FOLD_BITS'(hi) << TAP_A)
			^ (FOLD_BITS'(hi) << TAP_B)
			^ (FOLD_BITS'(hi) << TAP_C);
	end

	// Second fold: the overflow is short enough that no third pass is needed.
	always_comb begin
		ovf      = fold_s1[FOLD_BITS-1:FIELD_BITS];
		res_next = fold_s1[FIELD_BITS-1:0]
			^ FIELD_BITS'(ovf)
			^ (FIELD_BITS'(ovf) << TAP_A)
			^ (FIELD_BITS'(ovf) << TAP_B)
			^ (FIELD_BITS'(ovf) << TAP_C);
	end

	// Elastic handshake for both stages.
	assign ready_s1 = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (ready_s1) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			fold_s1 <= fold_next;
		end
		if (valid_s1 && ready_s1) begin
			res_s2 <= res_next;
		end
	end

	assign out_valid = valid_s2;
	assign out_elem  = res_s2;

endmodule
